@@ sv/simp_pkg.sv @@
// Shared types, codes and widths of the instruction executor.
`default_nettype none

package simp_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_REGS = 16;
  localparam int REG_AW   = 4;
  localparam int IO_COUNT = 5;
  localparam int IO_AW    = 3;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 9;
  localparam int STAT_W   = 2;
  localparam int PC_OUT_W = 9;
  localparam int IMM_W    = 12;
  localparam int CFG_ADDR_W = 3;

  // Highest I/O register index.
  localparam logic [ADDR_W-1:0] IO_LAST = 9'd4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXEC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_RUN  = 2'd0;
  localparam logic [STAT_W-1:0] ST_HALT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RSV  = 2'd2;

  // Opcodes.
  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_AND  = 4'h2;
  localparam logic [3:0] OP_OR   = 4'h3;
  localparam logic [3:0] OP_SLL  = 4'h4;
  localparam logic [3:0] OP_SRA  = 4'h5;
  localparam logic [3:0] OP_MAC  = 4'h6;
  localparam logic [3:0] OP_BR   = 4'h7;
  localparam logic [3:0] OP_IN   = 4'h8;
  localparam logic [3:0] OP_OUT  = 4'h9;
  localparam logic [3:0] OP_RSV  = 4'hA;
  localparam logic [3:0] OP_JAL  = 4'hB;
  localparam logic [3:0] OP_LW   = 4'hC;
  localparam logic [3:0] OP_SW   = 4'hD;
  localparam logic [3:0] OP_JR   = 4'hE;
  localparam logic [3:0] OP_HALT = 4'hF;

  // Branch conditions held in the rm field.
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_GT = 4'd2;
  localparam logic [3:0] COND_LT = 4'd3;
  localparam logic [3:0] COND_GE = 4'd4;
  localparam logic [3:0] COND_LE = 4'd5;

  // Link register of jal.
  localparam logic [REG_AW-1:0] LINK_REG = 4'd15;

  // Configuration register index.
  localparam logic [0:0] CFG_AUTO_IDX = 1'b0;

  // What a wrapped address is used for once it is ready.
  typedef enum logic [1:0] {
    PURP_PC   = 2'd0,
    PURP_LOAD = 2'd1,
    PURP_LW   = 2'd2,
    PURP_SW   = 2'd3
  } simp_purp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic take;
    logic fetch;
    logic decode;
    logic read2;
    logic exec;
    logic wrap_wait;
    logic ld_wb;
    logic resp_load;
  } simp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic halted;
    logic needs_wrap;
    logic wrap_done;
    logic wrap_lw;
  } simp_stat_t;

endpackage

`default_nettype wire

@@ sv/simp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module simp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/simp_wrap.sv @@
// Address wrap unit: reduces a 32-bit value modulo the memory depth.
`default_nettype none

module simp_wrap import simp_pkg::*; #(
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [WORD_W-1:0]        value,
  output logic                          done,
  output logic      [$clog2(DEPTH)-1:0] result
);

  localparam int  AW   = $clog2(DEPTH);
  localparam bit  POW2 = ((DEPTH & (DEPTH - 1)) == 0);

  if (POW2) begin : g_mask
    // A power-of-two depth only needs the low address bits.
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        result <= value[AW-1:0];
      end
    end
  end else begin : g_recip
    // Remainder by reciprocal multiplication in a registered pipeline. The value is
    // multiplied by the rounded-up reciprocal of the depth, the top bits of the
    // product give the exact quotient, and the low bits of
    // value - quotient * DEPTH are the remainder, since it is below 2**AW.
    localparam int QW = WORD_W + 1 - AW;
    localparam logic [WORD_W:0] RECIP =
      (WORD_W + 1)'(((64'd1 << (WORD_W + AW)) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
    localparam logic [AW-1:0] DEP_LO = AW'(DEPTH);

    logic                v1;
    logic                v2;
    logic [WORD_W-1:0]   val1;
    logic [2*WORD_W-1:0] prod1;
    logic [WORD_W:0]     hi_sum;
    logic [AW-1:0]       val2;
    logic [QW-1:0]       quot2;

    // Bits 32 and up of the full product; the top reciprocal bit adds the
    // value shifted by one word.
    assign hi_sum = {1'b0, prod1[2*WORD_W-1:WORD_W]} +
                    (RECIP[WORD_W] ? {1'b0, val1} : '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        v1   <= 1'b0;
        v2   <= 1'b0;
        done <= 1'b0;
      end else begin
        v1   <= start;
        v2   <= v1;
        done <= v2;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        val1  <= value;
        prod1 <= (2*WORD_W)'(value) * (2*WORD_W)'(RECIP[WORD_W-1:0]);
      end
      if (v1) begin
        val2  <= val1[AW-1:0];
        quot2 <= hi_sum[WORD_W:AW];
      end
      if (v2) begin
        result <= val2 - AW'(quot2[AW-1:0] * DEP_LO);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/simp_datapath.sv @@
// Datapath: memory, register file, ALU, I/O registers and result register.
`default_nettype none

module simp_datapath import simp_pkg::*; #(
  parameter int MEM_DEPTH = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire simp_cmd_t             cmd,
  output simp_stat_t                 stat,
  input  wire logic                  auto_count,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [ADDR_W-1:0]     address,
  input  wire logic [WORD_W-1:0]     data,
  output logic      [STAT_W-1:0]     status,
  output logic      [PC_OUT_W-1:0]   program_counter,
  output logic                       io_written,
  output logic      [IO_AW-1:0]      io_index,
  output logic      [WORD_W-1:0]     io_value,
  output logic      [WORD_W-1:0]     executed_count
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] PC_LAST = AW'(MEM_DEPTH - 1);

  // Architectural state.
  logic [AW-1:0]       pc;
  logic                halted;
  logic [WORD_W-1:0]   count;
  logic [WORD_W-1:0]   io_regs [IO_COUNT];
  logic [NUM_REGS-1:0] rf_valid;
  logic [AW-1:0]       clr_cnt;

  // Per-item working registers.
  logic [WORD_W-1:0] ir;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] prod;
  logic              va;
  logic              vb;
  logic [WORD_W-1:0] data_q;
  simp_purp_t        purp;
  logic              rsv_q;
  logic              iow_q;
  logic [IO_AW-1:0]  ioi_q;
  logic [WORD_W-1:0] iov_q;

  // Decoded fields.
  logic [3:0]        op;
  logic [REG_AW-1:0] rd;
  logic [3:0]        rm;
  logic [IMM_W-1:0]  imm;
  logic [WORD_W-1:0] simm;
  logic [4:0]        sh;

  assign op   = ir[31:28];
  assign rd   = ir[27:24];
  assign rm   = ir[15:12];
  assign imm  = ir[IMM_W-1:0];
  assign simm = {{(WORD_W - IMM_W){imm[IMM_W-1]}}, imm};
  assign sh   = b[4:0] + imm[4:0];

  // Main memory.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  simp_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Register file: two copies give two read ports.
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [WORD_W-1:0] rf_wdata;
  logic              rf_re;
  logic [REG_AW-1:0] rf_raddr_a;
  logic [REG_AW-1:0] rf_raddr_b;
  logic [WORD_W-1:0] rf_rdata_a;
  logic [WORD_W-1:0] rf_rdata_b;
  logic [WORD_W-1:0] rf_a;
  logic [WORD_W-1:0] rf_b;

  simp_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (rf_re),
    .raddr (rf_raddr_a),
    .rdata (rf_rdata_a)
  );

  simp_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (rf_re),
    .raddr (rf_raddr_b),
    .rdata (rf_rdata_b)
  );

  // First read gets rs and rt, the second gets rd and rm.
  assign rf_re      = cmd.decode | cmd.read2;
  assign rf_raddr_a = cmd.decode ? mem_rdata[23:20] : rd;
  assign rf_raddr_b = cmd.decode ? mem_rdata[19:16] : rm;
  // Entries never written since reset read as zero.
  assign rf_a       = va ? rf_rdata_a : '0;
  assign rf_b       = vb ? rf_rdata_b : '0;

  // Address wrap unit.
  logic              wrap_start;
  logic [WORD_W-1:0] wrap_value;
  logic              wrap_done;
  logic [AW-1:0]     wrap_result;
  logic              commit;

  simp_wrap #(.DEPTH(MEM_DEPTH)) u_wrap (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .value  (wrap_value),
    .done   (wrap_done),
    .result (wrap_result)
  );

  assign commit = cmd.wrap_wait & wrap_done;

  // Execute-stage logic. In the execute cycle rf_a holds R[rd], rf_b holds R[rm].
  logic [AW-1:0]     pc_seq;
  logic [WORD_W-1:0] io_idx;
  logic [WORD_W-1:0] in_val;
  logic              br_take;
  logic [WORD_W-1:0] alu;
  logic              wr_rd;
  logic              seq_adv;
  logic              needs_wrap;
  logic [WORD_W-1:0] target;
  logic              out_hit;

  assign pc_seq  = (pc == PC_LAST) ? '0 : pc + 1'b1;
  assign io_idx  = a + simm;
  assign in_val  = (io_idx <= WORD_W'(IO_LAST)) ? io_regs[io_idx[IO_AW-1:0]] : '0;
  assign out_hit = (io_idx == WORD_W'(1)) || (io_idx == WORD_W'(IO_LAST));

  always_comb begin
    unique case (rm)
      COND_EQ: br_take = (a == b);
      COND_NE: br_take = (a != b);
      COND_GT: br_take = ($signed(a) > $signed(b));
      COND_LT: br_take = ($signed(a) < $signed(b));
      COND_GE: br_take = ($signed(a) >= $signed(b));
      COND_LE: br_take = ($signed(a) <= $signed(b));
      default: br_take = 1'b0;
    endcase
  end

  always_comb begin
    alu        = '0;
    wr_rd      = 1'b0;
    seq_adv    = 1'b0;
    needs_wrap = 1'b0;
    target     = {{(WORD_W - IMM_W){1'b0}}, imm};
    unique case (op)
      OP_ADD: begin
        alu = a + b + simm; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_SUB: begin
        alu = a - b - simm; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_AND: begin
        alu = a & b & simm; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_OR: begin
        alu = a | b | simm; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_SLL: begin
        alu = a << sh; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_SRA: begin
        alu = $unsigned($signed(a) >>> sh); wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_MAC: begin
        alu = prod + rf_b + simm; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_BR: begin
        seq_adv = ~br_take; needs_wrap = br_take;
      end
      OP_IN: begin
        alu = in_val; wr_rd = 1'b1; seq_adv = 1'b1;
      end
      OP_OUT: begin
        seq_adv = 1'b1;
      end
      OP_RSV: begin
      end
      OP_JAL: begin
        alu = WORD_W'(pc_seq); needs_wrap = 1'b1;
      end
      OP_LW: begin
        seq_adv = 1'b1; needs_wrap = 1'b1; target = a + simm;
      end
      OP_SW: begin
        seq_adv = 1'b1; needs_wrap = 1'b1; target = a + simm;
      end
      OP_JR: begin
        needs_wrap = 1'b1;
        target = {{(WORD_W - IMM_W){1'b0}}, rf_a[IMM_W-1:0]};
      end
      OP_HALT: begin
      end
    endcase
  end

  assign wrap_start = (cmd.take & (kind == KIND_LOAD)) | (cmd.exec & needs_wrap);
  assign wrap_value = cmd.exec ? target : WORD_W'(address);

  // Register file write port.
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd;
    rf_wdata = alu;
    if (cmd.exec && op == OP_JAL) begin
      rf_we    = 1'b1;
      rf_waddr = LINK_REG;
    end else if (cmd.exec && wr_rd) begin
      rf_we = (rd != '0);
    end else if (cmd.ld_wb) begin
      rf_we    = (rd != '0);
      rf_wdata = mem_rdata;
    end
  end

  // Main memory ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wrap_result;
    mem_wdata = data_q;
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (commit && purp == PURP_LOAD) begin
      mem_we = 1'b1;
    end else if (commit && purp == PURP_SW) begin
      mem_we    = 1'b1;
      mem_wdata = rf_a;
    end
  end

  assign mem_re    = cmd.fetch | (commit & (purp == PURP_LW));
  assign mem_raddr = cmd.fetch ? pc : wrap_result;

  // Control-side architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      halted   <= 1'b0;
      count    <= '0;
      rf_valid <= '0;
      clr_cnt  <= '0;
      for (int i = 0; i < IO_COUNT; i++) begin
        io_regs[i] <= '0;
      end
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      if (cmd.take && kind == KIND_SET && address <= IO_LAST) begin
        io_regs[address[IO_AW-1:0]] <= data;
      end
      if (cmd.decode) begin
        count <= count + 1'b1;
        if (auto_count) begin
          io_regs[0] <= io_regs[0] + 1'b1;
        end
      end
      if (cmd.exec) begin
        if (seq_adv) begin
          pc <= pc_seq;
        end
        if (op == OP_HALT) begin
          halted <= 1'b1;
        end
        if (op == OP_OUT && out_hit) begin
          io_regs[io_idx[IO_AW-1:0]] <= rf_a;
        end
      end
      if (commit && purp == PURP_PC) begin
        pc <= wrap_result;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_q <= data;
      purp   <= PURP_LOAD;
      rsv_q  <= 1'b0;
      iow_q  <= 1'b0;
      ioi_q  <= '0;
      iov_q  <= '0;
    end
    if (cmd.decode) begin
      ir <= mem_rdata;
    end
    if (rf_re) begin
      va <= rf_valid[rf_raddr_a];
      vb <= rf_valid[rf_raddr_b];
    end
    if (cmd.read2) begin
      a    <= rf_a;
      b    <= rf_b;
      prod <= rf_a * rf_b;
    end
    if (cmd.exec) begin
      unique case (op)
        OP_LW:   purp <= PURP_LW;
        OP_SW:   purp <= PURP_SW;
        default: purp <= PURP_PC;
      endcase
      if (op == OP_RSV) begin
        rsv_q <= 1'b1;
      end
      if (op == OP_OUT && out_hit) begin
        iow_q <= 1'b1;
        ioi_q <= io_idx[IO_AW-1:0];
        iov_q <= rf_a;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      status          <= halted ? ST_HALT : (rsv_q ? ST_RSV : ST_RUN);
      program_counter <= PC_OUT_W'(pc);
      io_written      <= iow_q;
      io_index        <= ioi_q;
      io_value        <= iov_q;
      executed_count  <= count;
    end
  end

  assign stat.clear_done = (clr_cnt == PC_LAST);
  assign stat.halted     = halted;
  assign stat.needs_wrap = needs_wrap;
  assign stat.wrap_done  = wrap_done;
  assign stat.wrap_lw    = (purp == PURP_LW);

endmodule

`default_nettype wire

@@ sv/simp_ctrl.sv @@
// Controller state machine sequencing each item through the datapath.
`default_nettype none

module simp_ctrl import simp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] kind,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire simp_stat_t        stat,
  output simp_cmd_t              cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_FETCH  = 10'b0000000100,
    S_DECODE = 10'b0000001000,
    S_READ2  = 10'b0000010000,
    S_EXEC   = 10'b0000100000,
    S_WRAP   = 10'b0001000000,
    S_LDWB   = 10'b0010000000,
    S_RESP   = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } simp_state_t;

  simp_state_t state;
  simp_state_t state_next;
  logic        out_valid_next;
  logic        resp_ok;

  assign in_stall = (state != S_IDLE);
  assign resp_ok  = ~out_valid | ~out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (kind == KIND_LOAD) begin
            state_next = S_WRAP;
          end else if (kind == KIND_EXEC && !stat.halted) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_READ2;
      end
      S_READ2: begin
        cmd.read2  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.needs_wrap ? S_WRAP : S_RESP;
      end
      S_WRAP: begin
        cmd.wrap_wait = 1'b1;
        if (stat.wrap_done) begin
          state_next = stat.wrap_lw ? S_LDWB : S_RESP;
        end
      end
      S_LDWB: begin
        cmd.ld_wb  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (resp_ok) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.resp_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/simp_instruction_executor.sv @@
// Top level of the instruction executor: controller, datapath and config port.
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  kind, address, data
// result    out        out_valid/out_stall  status, program_counter, io_written,
//                                           io_index, io_value, executed_count
// config    in         APB psel/penable     paddr, pwdata, prdata (auto_count_io0)
//
// One item is worked on at a time. A load item goes from acceptance through the
// address wrap to the result; a set item, an item of unknown kind and an
// execute item while halted go straight to the result. An execute item passes
// through memory fetch, decode with the first register-file read, the second
// register-file read with the multiplier, execute, then the result. Branches
// taken, jal, jr, lw and sw add an address-wrap step, and lw a further step for
// its memory read. With a memory depth that is not a power of two, the wrap
// unit works by reciprocal multiplication and registers a product, a quotient
// and then the result. After reset a clearing pass writes zero to every memory
// word, one per cycle, and the block stalls its input until it ends; config
// writes are taken throughout. The next item is accepted while a result still
// waits; a stalled result holds the block only once the following result is ready.

module simp_instruction_executor import simp_pkg::*; #(
  parameter int MEM_DEPTH = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input item channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [ADDR_W-1:0]     address,
  input  wire logic [WORD_W-1:0]     data,
  // Result item channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [STAT_W-1:0]     status,
  output logic      [PC_OUT_W-1:0]   program_counter,
  output logic                       io_written,
  output logic      [IO_AW-1:0]      io_index,
  output logic      [WORD_W-1:0]     io_value,
  output logic      [WORD_W-1:0]     executed_count,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [WORD_W-1:0]     pwdata,
  output logic      [WORD_W-1:0]     prdata,
  output logic                       pready
);

  simp_cmd_t  cmd;
  simp_stat_t stat;
  logic       auto_count;
  logic       cfg_hit;

  // The single configuration register sits at byte address zero; the low two
  // address bits select a byte within the word and are ignored.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_AUTO_IDX);
  assign prdata  = cfg_hit ? WORD_W'(auto_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_count <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      auto_count <= pwdata[0];
    end
  end

  simp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  simp_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .auto_count      (auto_count),
    .kind            (kind),
    .address         (address),
    .data            (data),
    .status          (status),
    .program_counter (program_counter),
    .io_written      (io_written),
    .io_index        (io_index),
    .io_value        (io_value),
    .executed_count  (executed_count)
  );

endmodule

`default_nettype wire
